// ===== rtl/lsnp_pkg.sv =====
// ============================================================================
// lsnp_pkg
// Shared widths, register codes and pipeline stage words for the lattice
// site / neighbor / phase generator.
// ============================================================================
package lsnp_pkg;

    // field widths
    localparam int CW  = 6;        // coordinate
    localparam int EW  = 7;        // extent register
    localparam int IW  = 24;       // output index
    localparam int SW  = IW + 1;   // linear offset before halving (mod 2^SW)
    localparam int YTW = 2 * EW;   // y term, x*y stride
    localparam int ZTW = 3 * EW;   // z term, x*y*z stride
    localparam int PW  = 3;        // phase sign bits

    // configuration port
    localparam int AW = 5;         // byte address of five 32-bit registers
    localparam int DW = 32;

    localparam int MAX_EXTENT_DEF = 64;

    // register map, word index
    typedef enum logic [2:0] {
        REG_EXT_X  = 3'd0,
        REG_EXT_Y  = 3'd1,
        REG_EXT_Z  = 3'd2,
        REG_EXT_T  = 3'd3,
        REG_ANTI_T = 3'd4
    } t_reg_idx;

    // clamped extents and boundary mode
    typedef struct packed {
        logic [EW-1:0] ex;
        logic [EW-1:0] ey;
        logic [EW-1:0] ez;
        logic [EW-1:0] et;
        logic          anti;
    } t_ext;

    // coordinate with its forward and backward neighbors
    typedef struct packed {
        logic [EW-1:0] c;
        logic [EW-1:0] p;
        logic [EW-1:0] m;
    } t_axis;

    typedef struct packed {
        logic [YTW-1:0] c;
        logic [YTW-1:0] p;
        logic [YTW-1:0] m;
    } t_yterm;

    typedef struct packed {
        logic [ZTW-1:0] c;
        logic [ZTW-1:0] p;
        logic [ZTW-1:0] m;
    } t_zterm;

    typedef struct packed {
        logic [SW-1:0] c;
        logic [SW-1:0] p;
        logic [SW-1:0] m;
    } t_tterm;

    // per-site flags carried down the pipe
    typedef struct packed {
        logic          in_range;
        logic          par;
        logic [PW-1:0] phase;
    } t_flags;

    // after stage 1: neighbors, flags, y terms
    typedef struct packed {
        t_axis          ax;
        t_axis          ay;
        t_axis          az;
        t_axis          at;
        t_flags         fl;
        t_yterm         yt;
        logic [YTW-1:0] exy;
    } t_st1;

    // after stage 2: z terms
    typedef struct packed {
        t_axis          ax;
        t_axis          az;
        t_axis          at;
        t_flags         fl;
        t_yterm         yt;
        t_zterm         zt;
        logic [ZTW-1:0] exyz;
    } t_st2;

    // after stage 3: t terms and lattice volume
    typedef struct packed {
        t_axis         ax;
        t_flags        fl;
        t_yterm        yt;
        t_zterm        zt;
        t_tterm        tt;
        logic [SW-1:0] size;
    } t_st3;

endpackage

// ===== rtl/lsnp_cfg.sv =====
// ============================================================================
// lsnp_cfg
// APB register file for the lattice extents and the time boundary mode;
// presents clamped extents to the datapath.
// ============================================================================
module lsnp_cfg import lsnp_pkg::*; #(
    parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [DW-1:0] pwdata,
    output logic [DW-1:0] prdata,
    output logic          pready,
    output t_ext          o_ext
);

    logic [EW-1:0] r_ext_x, r_ext_y, r_ext_z, r_ext_t;
    logic          r_anti;
    logic          wr_en;
    t_reg_idx      idx;

    function automatic logic [EW-1:0] clamp(input logic [EW-1:0] e);
        // only taken when MAX_EXTENT < e, so the constant fits EW bits
        return (int'(e) > MAX_EXTENT) ? EW'(MAX_EXTENT) : e;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[AW-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_x <= EW'(4);
            r_ext_y <= EW'(4);
            r_ext_z <= EW'(4);
            r_ext_t <= EW'(4);
            r_anti  <= 1'b1;
        end else if (wr_en) begin
            unique case (idx)
                REG_EXT_X:  r_ext_x <= pwdata[EW-1:0];
                REG_EXT_Y:  r_ext_y <= pwdata[EW-1:0];
                REG_EXT_Z:  r_ext_z <= pwdata[EW-1:0];
                REG_EXT_T:  r_ext_t <= pwdata[EW-1:0];
                REG_ANTI_T: r_anti  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_EXT_X:  prdata = DW'(r_ext_x);
            REG_EXT_Y:  prdata = DW'(r_ext_y);
            REG_EXT_Z:  prdata = DW'(r_ext_z);
            REG_EXT_T:  prdata = DW'(r_ext_t);
            REG_ANTI_T: prdata = DW'(r_anti);
            default:    prdata = '0;
        endcase
    end

    assign o_ext.ex   = clamp(r_ext_x);
    assign o_ext.ey   = clamp(r_ext_y);
    assign o_ext.ez   = clamp(r_ext_z);
    assign o_ext.et   = clamp(r_ext_t);
    assign o_ext.anti = r_anti;

endmodule

// ===== rtl/lsnp_coord.sv =====
// ============================================================================
// lsnp_coord
// Input register and first stage: range check, wrapped neighbor
// coordinates, parity, phase signs and the y stride terms.
// ============================================================================
module lsnp_coord import lsnp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_coord_x,
    input  logic [CW-1:0] i_coord_y,
    input  logic [CW-1:0] i_coord_z,
    input  logic [CW-1:0] i_coord_t,
    input  t_ext          i_ext,
    output logic          o_vld,
    output t_st1          o_st1
);

    logic          r_v0, r_v1;
    logic [CW-1:0] r_x, r_y, r_z, r_t;
    t_st1          r_st1, n_st1;

    function automatic t_axis wrap(input logic [CW-1:0] c, input logic [EW-1:0] e);
        t_axis a;
        a.c = EW'(c);
        a.p = (a.c + EW'(1) == e) ? '0 : a.c + EW'(1);
        a.m = (a.c == '0) ? e - EW'(1) : a.c - EW'(1);
        return a;
    endfunction

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_coord_x;
            r_y <= i_coord_y;
            r_z <= i_coord_z;
            r_t <= i_coord_t;
        end
    end

    // stage 1 logic
    always_comb begin
        n_st1.ax = wrap(r_x, i_ext.ex);
        n_st1.ay = wrap(r_y, i_ext.ey);
        n_st1.az = wrap(r_z, i_ext.ez);
        n_st1.at = wrap(r_t, i_ext.et);

        n_st1.fl.in_range = (EW'(r_x) < i_ext.ex) && (EW'(r_y) < i_ext.ey) &&
                            (EW'(r_z) < i_ext.ez) && (EW'(r_t) < i_ext.et);
        n_st1.fl.par      = r_x[0] ^ r_y[0] ^ r_z[0] ^ r_t[0];
        // staggered signs: y from x, z from x+y, t from x+y+z, flipped on last t if anti
        n_st1.fl.phase[0] = r_x[0];
        n_st1.fl.phase[1] = r_x[0] ^ r_y[0];
        n_st1.fl.phase[2] = r_x[0] ^ r_y[0] ^ r_z[0] ^
                            (i_ext.anti && (EW'(r_t) + EW'(1) == i_ext.et));

        n_st1.yt.c = YTW'(n_st1.ay.c) * YTW'(i_ext.ex);
        n_st1.yt.p = YTW'(n_st1.ay.p) * YTW'(i_ext.ex);
        n_st1.yt.m = YTW'(n_st1.ay.m) * YTW'(i_ext.ex);
        n_st1.exy  = YTW'(i_ext.ex) * YTW'(i_ext.ey);
    end

    always_ff @(posedge i_clk) begin
        if (r_v0) begin
            r_st1 <= n_st1;
        end
    end

    assign o_vld = r_v1;
    assign o_st1 = r_st1;

endmodule

// ===== rtl/lsnp_term.sv =====
// ============================================================================
// lsnp_term
// Stages 2 and 3: z and t stride terms for the site and its neighbors,
// plus the lattice volume.
// ============================================================================
module lsnp_term import lsnp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_st1 i_st1,
    input  t_ext i_ext,
    output logic o_vld,
    output t_st3 o_st3
);

    logic r_v2, r_v3;
    t_st2 r_st2, n_st2;
    t_st3 r_st3, n_st3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_vld;
            r_v3 <= r_v2;
        end
    end

    // stage 2: z terms and x*y*z stride
    always_comb begin
        n_st2.ax   = i_st1.ax;
        n_st2.az   = i_st1.az;
        n_st2.at   = i_st1.at;
        n_st2.fl   = i_st1.fl;
        n_st2.yt   = i_st1.yt;
        n_st2.zt.c = ZTW'(i_st1.az.c) * ZTW'(i_st1.exy);
        n_st2.zt.p = ZTW'(i_st1.az.p) * ZTW'(i_st1.exy);
        n_st2.zt.m = ZTW'(i_st1.az.m) * ZTW'(i_st1.exy);
        n_st2.exyz = ZTW'(i_st1.exy) * ZTW'(i_ext.ez);
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_st2 <= n_st2;
        end
    end

    // stage 3: t terms and volume, kept modulo 2^SW
    always_comb begin
        n_st3.ax   = r_st2.ax;
        n_st3.fl   = r_st2.fl;
        n_st3.yt   = r_st2.yt;
        n_st3.zt   = r_st2.zt;
        n_st3.tt.c = SW'(r_st2.at.c) * SW'(r_st2.exyz);
        n_st3.tt.p = SW'(r_st2.at.p) * SW'(r_st2.exyz);
        n_st3.tt.m = SW'(r_st2.at.m) * SW'(r_st2.exyz);
        n_st3.size = SW'(r_st2.exyz) * SW'(i_ext.et);
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_st3 <= n_st3;
        end
    end

    assign o_vld = r_v3;
    assign o_st3 = r_st3;

endmodule

// ===== rtl/lsnp_index.sv =====
// ============================================================================
// lsnp_index
// Stages 4 and 5: linear offsets for the site and eight neighbors, then
// halving, even/odd half selection and the result register.
// ============================================================================
module lsnp_index import lsnp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  t_st3          i_st3,
    output logic          o_done,
    output logic [IW-1:0] o_site_index,
    output logic [IW-1:0] o_fwd_x,
    output logic [IW-1:0] o_fwd_y,
    output logic [IW-1:0] o_fwd_z,
    output logic [IW-1:0] o_fwd_t,
    output logic [IW-1:0] o_bwd_x,
    output logic [IW-1:0] o_bwd_y,
    output logic [IW-1:0] o_bwd_z,
    output logic [IW-1:0] o_bwd_t,
    output logic [PW-1:0] o_phase_signs,
    output logic          o_in_range
);

    // offset slots: site, fwd x y z t, bwd x y z t
    localparam int NS = 9;

    logic                r_v4, r_v5;
    logic [SW-1:0]       r_s [NS];
    logic [SW-1:0]       n_s [NS];
    t_flags              r_fl4;
    logic [SW-1:0]       r_size4;
    logic [IW-1:0]       r_idx [NS];
    logic [IW-1:0]       n_idx [NS];
    logic [PW-1:0]       r_phase;
    logic                r_in_range;
    logic [IW-1:0]       sizeh;

    function automatic logic [SW-1:0] lin(input logic [EW-1:0] x,
                                          input logic [YTW-1:0] y,
                                          input logic [ZTW-1:0] z,
                                          input logic [SW-1:0] t);
        return SW'(x) + SW'(y) + SW'(z) + t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_vld;
            r_v5 <= r_v4;
        end
    end

    // stage 4: four-term offsets
    always_comb begin
        n_s[0] = lin(i_st3.ax.c, i_st3.yt.c, i_st3.zt.c, i_st3.tt.c);
        n_s[1] = lin(i_st3.ax.p, i_st3.yt.c, i_st3.zt.c, i_st3.tt.c);
        n_s[2] = lin(i_st3.ax.c, i_st3.yt.p, i_st3.zt.c, i_st3.tt.c);
        n_s[3] = lin(i_st3.ax.c, i_st3.yt.c, i_st3.zt.p, i_st3.tt.c);
        n_s[4] = lin(i_st3.ax.c, i_st3.yt.c, i_st3.zt.c, i_st3.tt.p);
        n_s[5] = lin(i_st3.ax.m, i_st3.yt.c, i_st3.zt.c, i_st3.tt.c);
        n_s[6] = lin(i_st3.ax.c, i_st3.yt.m, i_st3.zt.c, i_st3.tt.c);
        n_s[7] = lin(i_st3.ax.c, i_st3.yt.c, i_st3.zt.m, i_st3.tt.c);
        n_s[8] = lin(i_st3.ax.c, i_st3.yt.c, i_st3.zt.c, i_st3.tt.m);
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_s     <= n_s;
            r_fl4   <= i_st3.fl;
            r_size4 <= i_st3.size;
        end
    end

    // stage 5: halve, place in own (site) or opposite (neighbors) half; zero if out of range
    assign sizeh = r_size4[SW-1:1];

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            if (!r_fl4.in_range) begin
                n_idx[i] = '0;
            end else if ((i == 0) ? r_fl4.par : !r_fl4.par) begin
                n_idx[i] = r_s[i][SW-1:1] + sizeh;
            end else begin
                n_idx[i] = r_s[i][SW-1:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4) begin
            r_idx      <= n_idx;
            r_phase    <= r_fl4.in_range ? r_fl4.phase : '0;
            r_in_range <= r_fl4.in_range;
        end
    end

    assign o_done        = r_v5;
    assign o_site_index  = r_idx[0];
    assign o_fwd_x       = r_idx[1];
    assign o_fwd_y       = r_idx[2];
    assign o_fwd_z       = r_idx[3];
    assign o_fwd_t       = r_idx[4];
    assign o_bwd_x       = r_idx[5];
    assign o_bwd_y       = r_idx[6];
    assign o_bwd_z       = r_idx[7];
    assign o_bwd_t       = r_idx[8];
    assign o_phase_signs = r_phase;
    assign o_in_range    = r_in_range;

endmodule

// ===== rtl/lattice_site_neighbor_phase_gen.sv =====
// Pipeline: a word accepted with start passes the input register and the
//   stage 1 to 5 registers and shows on the result ports with o_done high.
// Throughput: one site per cycle; busy stays low, the six-stage pipe of
//   small multipliers and adders never stalls and the receiver cannot stall.
// Reset: synchronous, active low; empties the pipe and loads extents of 4
//   with antiperiodic time boundaries.
// ============================================================================
// lattice_site_neighbor_phase_gen
// Even/odd-split 4D lattice index generator: site index, eight periodic
// neighbor indices and staggered phase signs for each site.
// ============================================================================
module lattice_site_neighbor_phase_gen import lsnp_pkg::*; #(
    parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // site command
    input  logic          start,
    output logic          busy,
    input  logic [CW-1:0] i_coord_x,
    input  logic [CW-1:0] i_coord_y,
    input  logic [CW-1:0] i_coord_z,
    input  logic [CW-1:0] i_coord_t,
    // results
    output logic          o_done,
    output logic [IW-1:0] o_site_index,
    output logic [IW-1:0] o_fwd_x,
    output logic [IW-1:0] o_fwd_y,
    output logic [IW-1:0] o_fwd_z,
    output logic [IW-1:0] o_fwd_t,
    output logic [IW-1:0] o_bwd_x,
    output logic [IW-1:0] o_bwd_y,
    output logic [IW-1:0] o_bwd_z,
    output logic [IW-1:0] o_bwd_t,
    output logic [PW-1:0] o_phase_signs,
    output logic          o_in_range,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [DW-1:0] pwdata,
    output logic [DW-1:0] prdata,
    output logic          pready
);

    t_ext ext;
    logic v1, v3;
    t_st1 st1;
    t_st3 st3;

    // a new word is taken every cycle
    assign busy = 1'b0;

    lsnp_cfg #(
        .MAX_EXTENT(MAX_EXTENT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ext   (ext)
    );

    lsnp_coord u_coord (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_coord_z (i_coord_z),
        .i_coord_t (i_coord_t),
        .i_ext     (ext),
        .o_vld     (v1),
        .o_st1     (st1)
    );

    lsnp_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (v1),
        .i_st1   (st1),
        .i_ext   (ext),
        .o_vld   (v3),
        .o_st3   (st3)
    );

    lsnp_index u_index (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (v3),
        .i_st3         (st3),
        .o_done        (o_done),
        .o_site_index  (o_site_index),
        .o_fwd_x       (o_fwd_x),
        .o_fwd_y       (o_fwd_y),
        .o_fwd_z       (o_fwd_z),
        .o_fwd_t       (o_fwd_t),
        .o_bwd_x       (o_bwd_x),
        .o_bwd_y       (o_bwd_y),
        .o_bwd_z       (o_bwd_z),
        .o_bwd_t       (o_bwd_t),
        .o_phase_signs (o_phase_signs),
        .o_in_range    (o_in_range)
    );

endmodule
